// ===== hw/rtl/tpe_pkg.sv =====
// Shared types and constants for the triangle plane equation core.
package tpe_pkg;

    localparam int COORD_W          = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NORMAL_W         = 16;
    localparam int OFFSET_W         = 24;

    typedef struct packed {
        logic signed [COORD_W-1:0] v0_x;
        logic signed [COORD_W-1:0] v0_y;
        logic signed [COORD_W-1:0] v0_z;
        logic signed [COORD_W-1:0] v1_x;
        logic signed [COORD_W-1:0] v1_y;
        logic signed [COORD_W-1:0] v1_z;
        logic signed [COORD_W-1:0] v2_x;
        logic signed [COORD_W-1:0] v2_y;
        logic signed [COORD_W-1:0] v2_z;
    } tpe_in_t;

    typedef struct packed {
        logic signed [NORMAL_W-1:0] normal_x;
        logic signed [NORMAL_W-1:0] normal_y;
        logic signed [NORMAL_W-1:0] normal_z;
        logic signed [OFFSET_W-1:0] plane_offset;
        logic                       degenerate;
    } tpe_out_t;

endpackage

// ===== hw/rtl/tpe_isqrt_pipe.sv =====
// Pipelined integer square root of a 64-bit value, one result bit per stage.
module tpe_isqrt_pipe #(
    parameter int TAG_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [63:0]      in_val,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [31:0]      out_root,
    output logic [TAG_W-1:0] out_tag
);
    localparam int STAGES = 32;

    logic [STAGES-1:0] valid_reg;
    logic [63:0]       rem_reg  [STAGES];
    logic [63:0]       res_reg  [STAGES];
    logic [TAG_W-1:0]  tag_reg  [STAGES];

    for (genvar j = 0; j < STAGES; j++) begin : g_stage
        logic             vld_in;
        logic [63:0]      rem_in;
        logic [63:0]      res_in;
        logic [TAG_W-1:0] tag_in;
        logic [63:0]      trial;
        logic [63:0]      rem_next;
        logic [63:0]      res_next;
        logic             fits;

        if (j == 0) begin : g_first
            assign vld_in = in_valid;
            assign rem_in = in_val;
            assign res_in = '0;
            assign tag_in = in_tag;
        end else begin : g_rest
            assign vld_in = valid_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign res_in = res_reg[j-1];
            assign tag_in = tag_reg[j-1];
        end

        assign trial    = res_in + (64'd1 << (62 - 2 * j));
        assign fits     = rem_in >= trial;
        assign rem_next = fits ? rem_in - trial : rem_in;
        assign res_next = fits ? (res_in >> 1) + (64'd1 << (62 - 2 * j)) : (res_in >> 1);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                res_reg[j] <= res_next;
                tag_reg[j] <= tag_in;
            end
        end

        if (j < STAGES - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= rem_next;
                end
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_root  = res_reg[STAGES-1][31:0];
    assign out_tag   = tag_reg[STAGES-1];

endmodule

// ===== hw/rtl/tpe_div_pipe.sv =====
// Pipelined restoring divider with several lanes, one quotient bit per stage.
module tpe_div_pipe #(
    parameter int LANES = 4,
    parameter int DEN_W = 35,
    parameter int QW    = 18,
    parameter int TAG_W = 5
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [LANES-1:0][DEN_W+QW-1:0]    in_num,
    input  logic [LANES-1:0][DEN_W-1:0]       in_den,
    input  logic [TAG_W-1:0]                  in_tag,
    output logic                              out_valid,
    output logic [LANES-1:0][QW-1:0]          out_quo,
    output logic [TAG_W-1:0]                  out_tag
);
    localparam int REM_W = DEN_W + QW;

    logic [QW-1:0]                  valid_reg;
    logic [LANES-1:0][REM_W-1:0]    rem_reg [QW];
    logic [LANES-1:0][DEN_W-1:0]    den_reg [QW];
    logic [LANES-1:0][QW-1:0]       quo_reg [QW];
    logic [TAG_W-1:0]               tag_reg [QW];

    // The numerator is known to be below the divisor times 2^QW.
    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic                           vld_in;
        logic [LANES-1:0][REM_W-1:0]    rem_in;
        logic [LANES-1:0][DEN_W-1:0]    den_in;
        logic [LANES-1:0][QW-1:0]       quo_in;
        logic [TAG_W-1:0]               tag_in;
        logic [LANES-1:0][REM_W-1:0]    rem_next;
        logic [LANES-1:0][QW-1:0]       quo_next;

        if (j == 0) begin : g_first
            assign vld_in = in_valid;
            assign rem_in = in_num;
            assign den_in = in_den;
            assign quo_in = '0;
            assign tag_in = in_tag;
        end else begin : g_rest
            assign vld_in = valid_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign tag_in = tag_reg[j-1];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [REM_W-1:0] trial;
            logic             fits;

            assign trial       = REM_W'(den_in[l]) << (QW - 1 - j);
            assign fits        = rem_in[l] >= trial;
            assign rem_next[l] = fits ? rem_in[l] - trial : rem_in[l];
            assign quo_next[l] = {quo_in[l][QW-2:0], fits};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[j] <= quo_next;
                tag_reg[j] <= tag_in;
            end
        end

        if (j < QW - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= rem_next;
                    den_reg[j] <= den_in;
                end
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_tag   = tag_reg[QW-1];

endmodule

// ===== hw/rtl/triangle_plane_equation_core.sv =====
// Top level of the triangle plane equation core: Newell normal, unit normal and plane offset.
//
// The core takes one triangle transaction per clock cycle while the pipeline is not
// stalled. The pipeline holds the 32-stage square root of the squared length
// and the 18-stage dividers that scale the normal and the offset; the remaining stages
// form the Newell products, the block scaling and the dot product. A one-entry skid
// register on the input drives s_ready from a register, so s_ready never depends on
// m_ready in the same cycle. It absorbs one transaction when the pipeline stalls, and
// s_ready then stays low until the output register is taken. The whole pipeline holds
// while the output register is full and not taken. A triangle whose Newell normal is
// exactly zero returns all zeros with degenerate set.
module triangle_plane_equation_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tpe_pkg::tpe_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tpe_pkg::tpe_out_t  m_data
);
    import tpe_pkg::*;

    localparam int ROOT_W = 32;
    localparam int DEN_W  = 35;
    localparam int QW     = 18;
    localparam int NUM_W  = DEN_W + QW;

    typedef struct packed {
        logic [2:0][30:0]    mm;
        logic [2:0]          neg;
        logic                deg;
        logic signed [51:0]  dot;
    } sq_tag_t;

    typedef struct packed {
        logic       deg;
        logic       negd;
        logic [2:0] neg;
    } dv_tag_t;

    // Input skid register and global pipeline enable.
    logic     en;
    logic     skid_full_reg;
    tpe_in_t  skid_data_reg;
    logic     pipe_valid;
    tpe_in_t  pipe_data;

    assign en         = m_ready || !m_valid;
    assign s_ready    = !skid_full_reg;
    assign pipe_valid = skid_full_reg || s_valid;
    assign pipe_data  = skid_full_reg ? skid_data_reg : s_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_full_reg <= 1'b0;
        end else if (en) begin
            skid_full_reg <= 1'b0;
        end else if (s_valid && !skid_full_reg) begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && s_valid && !skid_full_reg) begin
            skid_data_reg <= s_data;
        end
    end

    logic signed [COORD_W-1:0] p [3][3];

    always_comb begin
        p[0][0] = pipe_data.v0_x;
        p[0][1] = pipe_data.v0_y;
        p[0][2] = pipe_data.v0_z;
        p[1][0] = pipe_data.v1_x;
        p[1][1] = pipe_data.v1_y;
        p[1][2] = pipe_data.v1_z;
        p[2][0] = pipe_data.v2_x;
        p[2][1] = pipe_data.v2_y;
        p[2][2] = pipe_data.v2_z;
    end

    logic [6:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[5:0], pipe_valid};
        end
    end

    // Stage 1: edge differences, edge sums and the vertex sum.
    logic signed [16:0] dif_reg  [3][3];
    logic signed [16:0] add_reg  [3][3];
    logic signed [17:0] ssum_reg [3][3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    dif_reg[k][i] <= 17'(p[k][i]) - 17'(p[(k == 2) ? 0 : k + 1][i]);
                    add_reg[k][i] <= 17'(p[k][i]) + 17'(p[(k == 2) ? 0 : k + 1][i]);
                end
            end
            for (int i = 0; i < 3; i++) begin
                ssum_reg[0][i] <= 18'(p[0][i]) + 18'(p[1][i]) + 18'(p[2][i]);
            end
        end
    end

    // Stage 2: the nine Newell products.
    logic signed [33:0] prod_reg [3][3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                prod_reg[k][0] <= 34'(dif_reg[k][1]) * 34'(add_reg[k][2]);
                prod_reg[k][1] <= 34'(dif_reg[k][2]) * 34'(add_reg[k][0]);
                prod_reg[k][2] <= 34'(dif_reg[k][0]) * 34'(add_reg[k][1]);
            end
            ssum_reg[1] <= ssum_reg[0];
        end
    end

    // Stage 3: exact normal components.
    logic signed [35:0] nrm_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                nrm_reg[c] <= 36'(prod_reg[0][c]) + 36'(prod_reg[1][c]) + 36'(prod_reg[2][c]);
            end
            ssum_reg[2] <= ssum_reg[1];
        end
    end

    // Stage 4: magnitudes, signs and the bit length of the largest magnitude.
    function automatic logic [5:0] bit_length(input logic [35:0] v);
        logic [5:0] n;
        n = '0;
        for (int b = 0; b < 36; b++) begin
            if (v[b]) begin
                n = 6'(b + 1);
            end
        end
        return n;
    endfunction

    logic [35:0] mag_c [3];
    logic [35:0] mag_or;
    logic [35:0] mag_reg [3];
    logic [2:0]  neg_reg [4];
    logic [5:0]  bl_reg;
    logic        deg_reg [4];
    logic signed [17:0] ssum3_reg [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            mag_c[c] = nrm_reg[c][35] ? 36'(-nrm_reg[c]) : 36'(nrm_reg[c]);
        end
        mag_or = mag_c[0] | mag_c[1] | mag_c[2];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                mag_reg[c]    <= mag_c[c];
                neg_reg[0][c] <= nrm_reg[c][35];
            end
            bl_reg     <= bit_length(mag_or);
            deg_reg[0] <= (mag_or == '0);
            ssum3_reg  <= ssum_reg[2];
        end
    end

    // Stage 5: block scaling so that the largest magnitude has 31 bits.
    logic [35:0] shifted [3];
    logic [30:0] mm_reg [3][3];
    logic signed [17:0] ssum4_reg [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            shifted[c] = (bl_reg > 6'd31) ? (mag_reg[c] >> (bl_reg - 6'd31))
                                          : (mag_reg[c] << (6'd31 - bl_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                mm_reg[0][c] <= shifted[c][30:0];
            end
            neg_reg[1] <= neg_reg[0];
            deg_reg[1] <= deg_reg[0];
            ssum4_reg  <= ssum3_reg;
        end
    end

    // Stage 6: squares of the scaled components and the vertex-sum products.
    logic signed [31:0] msg [3];
    logic [61:0]        sqm_reg [3];
    logic signed [49:0] dp_reg [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            msg[c] = neg_reg[1][c] ? -$signed({1'b0, mm_reg[0][c]})
                                   : $signed({1'b0, mm_reg[0][c]});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                sqm_reg[c] <= 62'(mm_reg[0][c]) * 62'(mm_reg[0][c]);
                dp_reg[c]  <= 50'(ssum4_reg[c]) * 50'(msg[c]);
            end
            mm_reg[1]  <= mm_reg[0];
            neg_reg[2] <= neg_reg[1];
            deg_reg[2] <= deg_reg[1];
        end
    end

    // Stage 7: squared length and dot product.
    logic [63:0]        sq_reg;
    logic signed [51:0] dot_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg     <= 64'(sqm_reg[0]) + 64'(sqm_reg[1]) + 64'(sqm_reg[2]);
            dot_reg    <= 52'(dp_reg[0]) + 52'(dp_reg[1]) + 52'(dp_reg[2]);
            mm_reg[2]  <= mm_reg[1];
            neg_reg[3] <= neg_reg[2];
            deg_reg[3] <= deg_reg[2];
        end
    end

    // Square root of the squared length.
    sq_tag_t             sq_tag_in;
    sq_tag_t             sq_tag_out;
    logic                sq_valid;
    logic [ROOT_W-1:0]   len;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sq_tag_in.mm[c] = mm_reg[2][c];
        end
        sq_tag_in.neg = neg_reg[3];
        sq_tag_in.deg = deg_reg[3];
        sq_tag_in.dot = dot_reg;
    end

    tpe_isqrt_pipe #(
        .TAG_W ($bits(sq_tag_t))
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld_reg[6]),
        .in_val    (sq_reg),
        .in_tag    (sq_tag_in),
        .out_valid (sq_valid),
        .out_root  (len),
        .out_tag   (sq_tag_out)
    );

    // Stage 8: rounded dividends and divisors.
    logic [33:0]                len3;
    logic [51:0]                dot_mag;
    logic                       negd;
    logic                       div_vld_reg;
    logic [3:0][NUM_W-1:0]      num_reg;
    logic [3:0][DEN_W-1:0]      den_reg;
    dv_tag_t                    dv_tag_reg;

    assign len3    = {1'b0, len, 1'b0} + 34'(len);
    assign dot_mag = sq_tag_out.dot[51] ? 52'(-sq_tag_out.dot) : 52'(sq_tag_out.dot);
    // The offset is the negated dot product, so it is negative when the dot is positive.
    assign negd    = !sq_tag_out.dot[51] && (sq_tag_out.dot != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_vld_reg <= 1'b0;
        end else if (en) begin
            div_vld_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                num_reg[c] <= (NUM_W'(sq_tag_out.mm[c]) << (NORMAL_FRAC_BITS + 1)) + NUM_W'(len);
                den_reg[c] <= DEN_W'(len) << 1;
            end
            num_reg[3]      <= (NUM_W'(dot_mag) << 1) + NUM_W'(len3);
            den_reg[3]      <= DEN_W'(len3) << 1;
            dv_tag_reg.deg  <= sq_tag_out.deg;
            dv_tag_reg.negd <= negd;
            dv_tag_reg.neg  <= sq_tag_out.neg;
        end
    end

    logic                  res_valid;
    logic [3:0][QW-1:0]    quo;
    dv_tag_t               res_tag;

    tpe_div_pipe #(
        .LANES (4),
        .DEN_W (DEN_W),
        .QW    (QW),
        .TAG_W ($bits(dv_tag_t))
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_vld_reg),
        .in_num    (num_reg),
        .in_den    (den_reg),
        .in_tag    (dv_tag_reg),
        .out_valid (res_valid),
        .out_quo   (quo),
        .out_tag   (res_tag)
    );

    // Signs, clamps and the degenerate case.
    logic [QW-1:0]              qc [3];
    logic [NORMAL_W-1:0]        nv [3];
    logic [OFFSET_W-1:0]        lim;
    logic [OFFSET_W-1:0]        dq;
    logic [OFFSET_W-1:0]        dm;
    tpe_out_t                   res;
    logic                       out_valid_reg;
    tpe_out_t                   out_data_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            qc[c] = (quo[c] > QW'(32767)) ? QW'(32767) : quo[c];
            nv[c] = res_tag.neg[c] ? -qc[c][NORMAL_W-1:0] : qc[c][NORMAL_W-1:0];
        end
        lim = res_tag.negd ? OFFSET_W'(8388608) : OFFSET_W'(8388607);
        dq  = OFFSET_W'(quo[3]);
        dm  = (dq > lim) ? lim : dq;
        res.normal_x     = nv[0];
        res.normal_y     = nv[1];
        res.normal_z     = nv[2];
        res.plane_offset = res_tag.negd ? -dm : dm;
        res.degenerate   = 1'b0;
        if (res_tag.deg) begin
            res            = '0;
            res.degenerate = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== tb/triangle_plane_equation_core_tb.sv =====
// Self-checking testbench for the triangle plane equation core.
`timescale 1ns / 1ps

module triangle_plane_equation_core_tb;
    import tpe_pkg::*;

    localparam int N_RANDOM    = 450;
    localparam int DRAIN_AT    = 150;
    localparam int CALM_TAIL   = 50;
    localparam int LONG_STALL  = 300;
    localparam int CYCLE_LIMIT = 300000;
    localparam int LATENCY     = 59;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    tpe_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    tpe_out_t m_data;

    tpe_in_t  triangle_q[$];
    tpe_out_t plane_q[$];
    int       n_total;
    int       n_sent = 0;
    int       n_results = 0;
    int       gap_left = 0;
    int       stall_left = 0;
    bit       long_stall_done = 1'b0;
    int       n_errors = 0;
    longint   cycles = 0;

    triangle_plane_equation_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [63:0] isqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bv;
        res = 0;
        bv  = 64'h4000_0000_0000_0000;
        while (bv > n) bv >>= 2;
        while (bv != 0) begin
            if (n >= res + bv) begin
                n   = n - (res + bv);
                res = (res >> 1) + bv;
            end else begin
                res >>= 1;
            end
            bv >>= 2;
        end
        return res;
    endfunction

    // Newell normal formed exactly, block scaled to 31 bits, then normalized.
    function automatic tpe_out_t plane_of(tpe_in_t t);
        longint      p[3][3];
        longint      nrm[3];
        longint      vsum[3];
        longint      mag[3];
        longint      biggest;
        longint      dot;
        logic [63:0] mm[3];
        logic [63:0] sq, len, den, q, lim, a;
        int          bl, k, j;
        bit          negd;
        tpe_out_t    r;
        p[0][0] = t.v0_x; p[0][1] = t.v0_y; p[0][2] = t.v0_z;
        p[1][0] = t.v1_x; p[1][1] = t.v1_y; p[1][2] = t.v1_z;
        p[2][0] = t.v2_x; p[2][1] = t.v2_y; p[2][2] = t.v2_z;
        for (j = 0; j < 3; j++) begin
            nrm[j]  = 0;
            vsum[j] = 0;
        end
        for (k = 0; k < 3; k++) begin
            j = (k + 1) % 3;
            nrm[0] += (p[k][1] - p[j][1]) * (p[k][2] + p[j][2]);
            nrm[1] += (p[k][2] - p[j][2]) * (p[k][0] + p[j][0]);
            nrm[2] += (p[k][0] - p[j][0]) * (p[k][1] + p[j][1]);
            for (j = 0; j < 3; j++) vsum[j] += p[k][j];
        end
        r = '0;
        if (nrm[0] == 0 && nrm[1] == 0 && nrm[2] == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        biggest = 0;
        for (j = 0; j < 3; j++) begin
            mag[j] = (nrm[j] < 0) ? -nrm[j] : nrm[j];
            if (mag[j] > biggest) biggest = mag[j];
        end
        bl = 0;
        while (biggest != 0) begin
            bl++;
            biggest >>= 1;
        end
        sq = 0;
        for (j = 0; j < 3; j++) begin
            mm[j] = (bl > 31) ? (mag[j] >> (bl - 31)) : (mag[j] << (31 - bl));
            sq += mm[j] * mm[j];
        end
        len = isqrt(sq);
        dot = 0;
        for (j = 0; j < 3; j++) begin
            q = ((mm[j] << (NORMAL_FRAC_BITS + 1)) + len) / (2 * len);
            if (q > 32767) q = 32767;
            if (nrm[j] < 0) q = -q;
            case (j)
                0: r.normal_x = q[15:0];
                1: r.normal_y = q[15:0];
                default: r.normal_z = q[15:0];
            endcase
            dot += vsum[j] * ((nrm[j] < 0) ? -longint'(mm[j]) : longint'(mm[j]));
        end
        negd = dot > 0;
        a    = (dot < 0) ? -dot : dot;
        den  = 3 * len;
        lim  = negd ? 64'd8388608 : 64'd8388607;
        q    = (2 * a + den) / (2 * den);
        if (q > lim) q = lim;
        if (negd) q = -q;
        r.plane_offset = q[23:0];
        return r;
    endfunction

    function automatic tpe_in_t make_tri(int c[9]);
        tpe_in_t t;
        t = {c[0][15:0], c[1][15:0], c[2][15:0], c[3][15:0], c[4][15:0],
             c[5][15:0], c[6][15:0], c[7][15:0], c[8][15:0]};
        return t;
    endfunction

    function automatic void queue_triangle(int c[9]);
        triangle_q = {triangle_q, make_tri(c)};
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    initial begin
        int c[9];
        int d[3];
        int k, kind;
        // Directed: degenerate cases, extremes and simple axis planes.
        c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                              queue_triangle(c);
        c = '{100, 200, 300, 100, 200, 300, 100, 200, 300};            queue_triangle(c);
        c = '{0, 0, 0, 256, 256, 256, 512, 512, 512};                  queue_triangle(c);
        c = '{5, 5, 5, 5, 5, 5, 700, -3, 40};                          queue_triangle(c);
        c = '{0, 0, 256, 256, 0, 256, 0, 256, 256};                    queue_triangle(c);
        c = '{0, 0, -256, 0, 256, -256, 256, 0, -256};                 queue_triangle(c);
        c = '{1000, 0, 0, 1000, 256, 0, 1000, 0, 256};                 queue_triangle(c);
        c = '{0, -900, 0, 256, -900, 0, 0, -900, 256};                 queue_triangle(c);
        c = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767};
        queue_triangle(c);
        c = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
        queue_triangle(c);
        c = '{32767, 32767, 32767, 32767, -32768, -32768, -32768, 32767, -32768};
        queue_triangle(c);
        c = '{-32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767, -32768};
        queue_triangle(c);
        c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};                              queue_triangle(c);
        c = '{0, 0, 0, 0, 1, 0, 1, 0, 0};                              queue_triangle(c);
        c = '{-1, -1, -1, 0, 0, 0, 1, 2, 3};                           queue_triangle(c);
        c = '{0, 0, 32767, 32767, 0, 32767, 0, 32767, 32767};          queue_triangle(c);
        c = '{0, 0, -32768, -32768, 0, -32768, 0, -32768, -32768};     queue_triangle(c);
        c = '{1, 2, 3, 4, 5, 6, 7, 8, 10};                             queue_triangle(c);
        for (k = 0; k < N_RANDOM; k++) begin
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                foreach (c[j]) c[j] = $signed($urandom_range(0, 65535) - 32768);
            end else if (kind <= 5) begin
                foreach (c[j]) c[j] = $urandom_range(0, 600) - 300;
            end else if (kind == 6) begin
                foreach (c[j]) c[j] = pick_extreme();
            end else if (kind == 7) begin
                // Collinear vertices give a zero normal.
                for (int j = 0; j < 3; j++) begin
                    c[j] = $urandom_range(0, 20000) - 10000;
                    d[j] = $urandom_range(0, 200) - 100;
                    c[j + 3] = c[j] + d[j];
                    c[j + 6] = c[j] + 2 * d[j];
                end
            end else if (kind == 8) begin
                foreach (c[j]) c[j] = $signed($urandom_range(0, 65535) - 32768);
                for (int j = 0; j < 3; j++) c[j + 3 * $urandom_range(1, 2)] = c[j];
            end else begin
                // Flat in one axis.
                foreach (c[j]) c[j] = $signed($urandom_range(0, 65535) - 32768);
                d[0] = $urandom_range(0, 2);
                c[d[0] + 3] = c[d[0]];
                c[d[0] + 6] = c[d[0]];
            end
            queue_triangle(c);
        end
        n_total = triangle_q.size();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        wait (n_sent == n_total && plane_q.size() == 0);
        repeat (LATENCY + 20) @(posedge aclk);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Source side: offers triangles, with random gaps and one full drain pause.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                plane_q = {plane_q, plane_of(s_data)};
                n_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (triangle_q.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (n_sent == DRAIN_AT && plane_q.size() != 0) begin
                    s_valid <= 1'b0;
                end else if (n_sent < n_total - CALM_TAIL && $urandom_range(0, 5) == 0) begin
                    gap_left <= $urandom_range(0, 7);
                    s_valid  <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_data  <= triangle_q.pop_front();
                end
            end
        end
    end

    // Result side: random stalls plus one long hold-off to back up the pipeline.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (plane_q.size() == 0) begin
                    $error("result transaction with no triangle outstanding");
                    n_errors++;
                end else begin
                    tpe_out_t exp_p;
                    exp_p = plane_q.pop_front();
                    if (m_data.normal_x !== exp_p.normal_x) begin
                        $error("normal_x: expected %0d, got %0d", exp_p.normal_x, m_data.normal_x);
                        n_errors++;
                    end
                    if (m_data.normal_y !== exp_p.normal_y) begin
                        $error("normal_y: expected %0d, got %0d", exp_p.normal_y, m_data.normal_y);
                        n_errors++;
                    end
                    if (m_data.normal_z !== exp_p.normal_z) begin
                        $error("normal_z: expected %0d, got %0d", exp_p.normal_z, m_data.normal_z);
                        n_errors++;
                    end
                    if (m_data.plane_offset !== exp_p.plane_offset) begin
                        $error("plane_offset: expected %0d, got %0d",
                               exp_p.plane_offset, m_data.plane_offset);
                        n_errors++;
                    end
                    if (m_data.degenerate !== exp_p.degenerate) begin
                        $error("degenerate: expected %0d, got %0d",
                               exp_p.degenerate, m_data.degenerate);
                        n_errors++;
                    end
                end
                n_results++;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!long_stall_done && n_results >= 60) begin
                long_stall_done <= 1'b1;
                stall_left      <= LONG_STALL;
                m_ready         <= 1'b0;
            end else if (n_sent < n_total - CALM_TAIL && $urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(0, 7);
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

// ===== triangle_plane_equation_core.f =====
hw/rtl/tpe_pkg.sv
hw/rtl/tpe_isqrt_pipe.sv
hw/rtl/tpe_div_pipe.sv
hw/rtl/triangle_plane_equation_core.sv
tb/triangle_plane_equation_core_tb.sv
